// ----- rtl/core/tcw_pkg.sv -----
`default_nettype none
package tcw_pkg;

   localparam int XW    = 7;
   localparam int YW    = 5;
   localparam int CHW   = 8;
   localparam int CELLW = 16;

   localparam logic [CHW-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHW-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHW-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHW-1:0] CH_TAB       = 8'd9;
   localparam logic [CHW-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHW-1:0] RESET_COLOR  = 8'd7;
   localparam int             TAB_STEP     = 8;

   typedef enum logic [1:0] {
      MODE_PUT   = 2'd0,
      MODE_SET   = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_READ  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      K_PRINT,
      K_NEWLINE,
      K_RETURN,
      K_BACKSPACE,
      K_TAB
   } ch_kind_type;

   typedef enum logic [3:0] {
      CUR_HOLD,
      CUR_COL0,
      CUR_NEWLINE,
      CUR_LEFT,
      CUR_UP,
      CUR_TAB,
      CUR_RIGHT,
      CUR_SET,
      CUR_HOME,
      CUR_FOUND
   } cur_op_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CHAR,
      WR_BS,
      WR_FILL,
      WR_INIT,
      WR_COPY
   } wr_op_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_CELL,
      RD_COPY,
      RD_SEARCH
   } rd_op_type;

   typedef struct packed {
      logic [1:0]     mode;
      logic [CHW-1:0] char_code;
      logic [XW-1:0]  pos_x;
      logic [YW-1:0]  pos_y;
   } req_type;

   typedef struct packed {
      logic [YW-1:0]    cursor_row;
      logic [XW-1:0]    cursor_column;
      logic [CELLW-1:0] cell_value;
      logic             scrolled;
   } rsp_type;

   typedef struct packed {
      logic       load_req;
      cur_op_type cur_op;
      wr_op_type  wr_op;
      rd_op_type  rd_op;
      logic       idx_clear;
      logic       idx_inc;
      logic       col_load;
      logic       col_dec;
      logic       set_scroll;
      logic       cell_load;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      mode_type    mode;
      ch_kind_type kind;
      logic        x_zero;
      logic        y_zero;
      logic        y_last;
      logic        x_wrap;
      logic        tab_wrap;
      logic        in_range;
      logic        idx_last;
      logic        copy_last;
      logic        col_one;
      logic        cell_nonspace;
      logic        rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/tcw_ctrl.sv -----
`default_nettype none
module tcw_ctrl
   import tcw_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_EXEC,
      S_FILL,
      S_COPY,
      S_DRAIN,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_READ,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      state_in  = state_ff;
      case (state_ff)
         S_INIT: begin
            cmd.wr_op   = WR_INIT;
            cmd.idx_inc = 1'b1;
            if (sts.idx_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (sts.mode)
               MODE_PUT: begin
                  case (sts.kind)
                     K_NEWLINE: begin
                        cmd.cur_op = CUR_NEWLINE;
                        if (sts.y_last) begin
                           cmd.set_scroll = 1'b1;
                           cmd.idx_clear  = 1'b1;
                           state_in       = S_COPY;
                        end
                     end
                     K_RETURN: begin
                        cmd.cur_op = CUR_COL0;
                     end
                     K_BACKSPACE: begin
                        if (!sts.x_zero) begin
                           cmd.wr_op  = WR_BS;
                           cmd.cur_op = CUR_LEFT;
                        end else if (!sts.y_zero) begin
                           cmd.cur_op   = CUR_UP;
                           cmd.col_load = 1'b1;
                           state_in     = S_SRCH_RD;
                        end
                     end
                     K_TAB: begin
                        if (sts.tab_wrap) begin
                           cmd.cur_op = CUR_NEWLINE;
                           if (sts.y_last) begin
                              cmd.set_scroll = 1'b1;
                              cmd.idx_clear  = 1'b1;
                              state_in       = S_COPY;
                           end
                        end else begin
                           cmd.cur_op = CUR_TAB;
                        end
                     end
                     default: begin
                        cmd.wr_op = WR_CHAR;
                        if (sts.x_wrap) begin
                           cmd.cur_op = CUR_NEWLINE;
                           if (sts.y_last) begin
                              cmd.set_scroll = 1'b1;
                              cmd.idx_clear  = 1'b1;
                              state_in       = S_COPY;
                           end
                        end else begin
                           cmd.cur_op = CUR_RIGHT;
                        end
                     end
                  endcase
               end
               MODE_SET: begin
                  if (sts.in_range) begin
                     cmd.cur_op = CUR_SET;
                  end
               end
               MODE_CLEAR: begin
                  cmd.cur_op    = CUR_HOME;
                  cmd.idx_clear = 1'b1;
                  state_in      = S_FILL;
               end
               default: begin
                  if (sts.in_range) begin
                     cmd.rd_op = RD_CELL;
                     state_in  = S_READ;
                  end
               end
            endcase
         end
         S_FILL: begin
            cmd.wr_op   = WR_FILL;
            cmd.idx_inc = 1'b1;
            if (sts.idx_last) begin
               state_in = S_DONE;
            end
         end
         S_COPY: begin
            cmd.rd_op   = RD_COPY;
            cmd.wr_op   = WR_COPY;
            cmd.idx_inc = 1'b1;
            if (sts.copy_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            cmd.wr_op = WR_COPY;
            state_in  = S_FILL;
         end
         S_SRCH_RD: begin
            cmd.rd_op = RD_SEARCH;
            state_in  = S_SRCH_CHK;
         end
         S_SRCH_CHK: begin
            if (sts.cell_nonspace) begin
               cmd.cur_op = CUR_FOUND;
               state_in   = S_DONE;
            end else if (sts.col_one) begin
               cmd.cur_op = CUR_COL0;
               state_in   = S_DONE;
            end else begin
               cmd.col_dec = 1'b1;
               state_in    = S_SRCH_RD;
            end
         end
         S_READ: begin
            cmd.cell_load = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               req_ready    = 1'b1;
               if (req_valid) begin
                  cmd.load_req = 1'b1;
                  state_in     = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/tcw_dpath.sv -----
`default_nettype none
module tcw_dpath
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire cmd_type        cmd,
   output sts_type             sts,
   input  wire req_type        req_data,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_type             rsp_data,
   input  wire logic           csr_valid,
   input  wire logic [CHW-1:0] csr_data
);

   localparam int CELLS = ROWS * COLUMNS;
   localparam int IDX_W = $clog2(CELLS);
   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(CELLS - 1);
   localparam logic [IDX_W-1:0] COPY_LAST = IDX_W'((ROWS - 1) * COLUMNS - 1);
   localparam logic [IDX_W-1:0] COLS_IDX  = IDX_W'(COLUMNS);
   localparam logic [XW-1:0]    COL_LAST  = XW'(COLUMNS - 1);
   localparam logic [YW-1:0]    ROW_LAST  = YW'(ROWS - 1);
   localparam logic [XW:0]      COLS_WIDE = (XW+1)'(COLUMNS);
   localparam logic [YW:0]      ROWS_WIDE = (YW+1)'(ROWS);
   localparam logic [XW:0]      TAB_ADD   = (XW+1)'(TAB_STEP);
   localparam logic [XW:0]      TAB_MASK  = ~((XW+1)'(TAB_STEP - 1));

   function automatic logic [IDX_W-1:0] cell_addr(input logic [YW-1:0] y,
                                                  input logic [XW-1:0] x);
      cell_addr = IDX_W'(y) * COLS_IDX + IDX_W'(x);
   endfunction

   logic [CELLW-1:0] mem [CELLS];

   req_type          req_ff;
   logic [XW-1:0]    cur_x_ff, cur_x_in;
   logic [YW-1:0]    cur_y_ff, cur_y_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [XW-1:0]    col_ff, col_in;
   logic [CHW-1:0]   text_color_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pend_addr_ff;
   logic [CELLW-1:0] rd_data_ff;
   logic [CELLW-1:0] cell_ff;
   logic             scrolled_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [CELLW-1:0] mem_wd;
   logic             mem_re;
   logic [IDX_W-1:0] mem_ra;
   logic [IDX_W-1:0] cur_addr;
   logic [XW:0]      tab_x;
   logic [XW:0]      right_x;

   assign cur_addr = cell_addr(cur_y_ff, cur_x_ff);
   assign tab_x    = ({1'b0, cur_x_ff} + TAB_ADD) & TAB_MASK;
   assign right_x  = {1'b0, cur_x_ff} + (XW+1)'(1);

   // status toward the controller
   always_comb begin
      sts.mode = mode_type'(req_ff.mode);
      case (req_ff.char_code)
         CH_NEWLINE:   sts.kind = K_NEWLINE;
         CH_RETURN:    sts.kind = K_RETURN;
         CH_BACKSPACE: sts.kind = K_BACKSPACE;
         CH_TAB:       sts.kind = K_TAB;
         default:      sts.kind = K_PRINT;
      endcase
      sts.x_zero        = (cur_x_ff == '0);
      sts.y_zero        = (cur_y_ff == '0);
      sts.y_last        = (cur_y_ff == ROW_LAST);
      sts.x_wrap        = (right_x >= COLS_WIDE);
      sts.tab_wrap      = (tab_x >= COLS_WIDE);
      sts.in_range      = ({1'b0, req_ff.pos_x} < COLS_WIDE) &&
                          ({1'b0, req_ff.pos_y} < ROWS_WIDE);
      sts.idx_last      = (idx_ff == IDX_LAST);
      sts.copy_last     = (idx_ff == COPY_LAST);
      sts.col_one       = (col_ff == XW'(1));
      sts.cell_nonspace = (rd_data_ff[CHW-1:0] != CH_SPACE);
      sts.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

   // memory port selection
   always_comb begin
      mem_we = 1'b0;
      mem_wa = cur_addr;
      mem_wd = {text_color_ff, CH_SPACE};
      case (cmd.wr_op)
         WR_CHAR: begin
            mem_we = 1'b1;
            mem_wd = {text_color_ff, req_ff.char_code};
         end
         WR_BS: begin
            mem_we = 1'b1;
            mem_wa = cur_addr - IDX_W'(1);
         end
         WR_FILL: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
         end
         WR_INIT: begin
            mem_we = 1'b1;
            mem_wa = idx_ff;
            mem_wd = {RESET_COLOR, CH_SPACE};
         end
         WR_COPY: begin
            mem_we = pend_ff;
            mem_wa = pend_addr_ff;
            mem_wd = rd_data_ff;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase

      mem_re = 1'b1;
      mem_ra = idx_ff + COLS_IDX;
      case (cmd.rd_op)
         RD_CELL:   mem_ra = cell_addr(req_ff.pos_y, req_ff.pos_x);
         RD_COPY:   mem_ra = idx_ff + COLS_IDX;
         RD_SEARCH: mem_ra = cell_addr(cur_y_ff, col_ff);
         default:   mem_re = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

   // cursor update
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      case (cmd.cur_op)
         CUR_COL0: cur_x_in = '0;
         CUR_NEWLINE: begin
            cur_x_in = '0;
            if (!sts.y_last) begin
               cur_y_in = cur_y_ff + YW'(1);
            end
         end
         CUR_LEFT:  cur_x_in = cur_x_ff - XW'(1);
         CUR_UP:    cur_y_in = cur_y_ff - YW'(1);
         CUR_TAB:   cur_x_in = tab_x[XW-1:0];
         CUR_RIGHT: cur_x_in = right_x[XW-1:0];
         CUR_SET: begin
            cur_x_in = req_ff.pos_x;
            cur_y_in = req_ff.pos_y;
         end
         CUR_HOME: begin
            cur_x_in = '0;
            cur_y_in = '0;
         end
         CUR_FOUND: cur_x_in = (col_ff == COL_LAST) ? col_ff : col_ff + XW'(1);
         default: begin
            cur_x_in = cur_x_ff;
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + IDX_W'(1);
      end
      col_in = col_ff;
      if (cmd.col_load) begin
         col_in = COL_LAST;
      end else if (cmd.col_dec) begin
         col_in = col_ff - XW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         text_color_ff <= RESET_COLOR;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
         idx_ff   <= idx_in;
         pend_ff  <= (cmd.rd_op == RD_COPY);
         if (csr_valid) begin
            text_color_ff <= csr_data;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      pend_addr_ff <= idx_ff;
      if (cmd.load_req) begin
         req_ff      <= req_data;
         cell_ff     <= '0;
         scrolled_ff <= 1'b0;
      end else begin
         if (cmd.cell_load) begin
            cell_ff <= rd_data_ff;
         end
         if (cmd.set_scroll) begin
            scrolled_ff <= 1'b1;
         end
      end
      if (cmd.rsp_load) begin
         rsp_ff.cursor_row    <= cur_y_ff;
         rsp_ff.cursor_column <= cur_x_ff;
         rsp_ff.cell_value    <= cell_ff;
         rsp_ff.scrolled      <= scrolled_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/core/text_console_writer.sv -----
// Character-cell text console: a ROWS x COLUMNS screen of 16-bit cells
// (character byte low, attribute byte high) plus a cursor.
//
// Channels: req_* carries one command item (mode, char_code, pos_x,
// pos_y); rsp_* returns one item per command with the cursor position
// after it, the cell read (read command only, else zero) and a scroll
// flag. csr_* writes the text attribute byte; it is always ready.
//
// A plain command (printable, return, tab or newline without scroll,
// set cursor, backspace within a line) passes through an execute state
// and a done state, accept to result; a read adds a read state between
// them. A new item is accepted in the cycle its predecessor's result is
// registered, once the result register is free. Work that walks the
// single-port-write screen memory stalls input: clear, a scroll, and
// backspace onto the previous line, which searches that line one column
// at a time from the last.
//
// Reset: cursor goes to 0,0, attribute to 7, then a clearing pass writes
// every cell to a space in attribute 7 with req_ready low throughout. A
// stalled receiver holds the registered result; one further command may
// complete behind it before input stops.
`default_nettype none
module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire req_type        req_data,
   output logic                rsp_valid,
   input  wire logic           rsp_ready,
   output rsp_type             rsp_data,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [CHW-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   // attribute writes land at once; the block is idle by contract
   assign csr_ready = 1'b1;

   // sequence commands, memory sweeps and the backspace search
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // screen memory, cursor, counters and the result register
   tcw_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid & csr_ready),
      .csr_data  (csr_data)
   );

endmodule
`default_nettype wire

// ----- tb/tb_text_console_writer.sv -----
`timescale 1ns / 1ps
module tb_text_console_writer;
   import tcw_pkg::*;

   // Screen geometry; must match the parameters given to the instance below.
   localparam int COLS = 80;
   localparam int NROWS = 25;
   localparam int CELLS = COLS * NROWS;
   localparam int REQ_W = $bits(req_type);
   localparam logic [CELLW-1:0] RESET_BLANK = {RESET_COLOR, CH_SPACE};
   // Slowest work is a full clear or a scroll, plus a receiver stall; allow
   // several times that before declaring a hang.
   localparam int STALL_LIMIT = 12000;

   typedef struct {
      req_type cmd;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [CHW-1:0] csr_data;

   // Shadow copy of the console: screen cells, cursor and attribute byte.
   logic [CELLW-1:0] shadow_screen [CELLS];
   int               cur_row;
   int               cur_col;
   logic [CHW-1:0]   attr_now;

   // Results owed by the block, oldest first.
   rsp_type pending_results [$];

   dir_row_type dir_rows [32];
   int          dir_count = 0;

   int  items_sent = 0;
   int  results_seen = 0;
   int  errors = 0;
   int  scrolls_seen = 0;
   int  clears_seen = 0;
   int  reads_seen = 0;
   bit  calm_tail = 1'b0;

   text_console_writer #(
      .COLUMNS(COLS),
      .ROWS   (NROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Console predictor
   // ---------------------------------------------------------------------

   // Drop to column 0 of the next row; scroll the screen up when it runs off
   // the bottom. Return 1 when a scroll happened.
   function automatic bit advance_line();
      cur_col = 0;
      cur_row++;
      if (cur_row >= NROWS) begin
         for (int i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
         for (int i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = {attr_now, CH_SPACE};
         cur_row = NROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit put_char(logic [CHW-1:0] c);
      int col;
      case (c)
         CH_NEWLINE: return advance_line();
         CH_RETURN: cur_col = 0;
         CH_BACKSPACE: begin
            if (cur_col > 0) begin
               // Step left and blank the cell.
               cur_col--;
               shadow_screen[cur_row * COLS + cur_col] = {attr_now, CH_SPACE};
            end else if (cur_row > 0) begin
               // Climb to the previous row and land just past its last
               // non-space character; column 0 is never inspected, and a
               // full line clamps to the last column.
               cur_row--;
               col = COLS - 1;
               while (col > 0) begin
                  if (shadow_screen[cur_row * COLS + col][CHW-1:0] != CH_SPACE) begin
                     col++;
                     break;
                  end
                  col--;
               end
               if (col >= COLS) col = COLS - 1;
               cur_col = col;
            end
         end
         CH_TAB: begin
            cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
            if (cur_col >= COLS) return advance_line();
         end
         default: begin
            shadow_screen[cur_row * COLS + cur_col] = {attr_now, c};
            cur_col++;
            if (cur_col >= COLS) return advance_line();
         end
      endcase
      return 1'b0;
   endfunction

   // Apply one command to the shadow console and return the result it owes.
   function automatic rsp_type apply_command(req_type r);
      rsp_type o;
      bit      fits;
      o = '0;
      fits = (int'(r.pos_x) < COLS) && (int'(r.pos_y) < NROWS);
      case (r.mode)
         MODE_PUT: o.scrolled = put_char(r.char_code);
         MODE_SET: begin
            if (fits) begin
               cur_col = r.pos_x;
               cur_row = r.pos_y;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < CELLS; i++) shadow_screen[i] = {attr_now, CH_SPACE};
            cur_row = 0;
            cur_col = 0;
         end
         default: begin
            if (fits) o.cell_value = shadow_screen[int'(r.pos_y) * COLS + int'(r.pos_x)];
         end
      endcase
      o.cursor_row = YW'(cur_row);
      o.cursor_column = XW'(cur_col);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic req_type make_cmd(mode_type m, int ch, int x, int y);
      req_type r;
      r.mode = m;
      r.char_code = CHW'(ch);
      r.pos_x = XW'(x);
      r.pos_y = YW'(y);
      return r;
   endfunction

   function automatic logic [CHW-1:0] control_char(int k);
      case (k)
         0: return CH_NEWLINE;
         1: return CH_RETURN;
         2: return CH_BACKSPACE;
         default: return CH_TAB;
      endcase
   endfunction

   // Append one row to the directed table; typed rows carry their own result.
   function automatic void add_row(mode_type m, int ch, int x, int y, bit typed = 1'b0,
                                   int row = 0, int col = 0, int cell_val = 0,
                                   bit scr = 1'b0);
      dir_rows[dir_count].cmd = make_cmd(m, ch, x, y);
      dir_rows[dir_count].typed = typed;
      dir_rows[dir_count].want.cursor_row = YW'(row);
      dir_rows[dir_count].want.cursor_column = XW'(col);
      dir_rows[dir_count].want.cell_value = CELLW'(cell_val);
      dir_rows[dir_count].want.scrolled = scr;
      dir_count++;
   endfunction

   // One loose command of any kind, with the unused fields left random.
   function automatic req_type random_cmd();
      req_type r;
      int      pick;
      pick = $urandom_range(0, 99);
      r.char_code = CHW'($urandom_range(0, 255));
      r.pos_x = XW'($urandom_range(0, 127));
      r.pos_y = YW'($urandom_range(0, 31));
      if (pick < 45) begin
         r.mode = MODE_PUT;
         if (pick < 20) r.char_code = control_char($urandom_range(0, 3));
      end else if (pick < 70) begin
         r.mode = MODE_SET;
         if (pick < 62) begin
            r.pos_x = XW'($urandom_range(0, COLS - 1));
            r.pos_y = YW'($urandom_range(0, NROWS - 1));
         end
      end else if (pick < 97) begin
         r.mode = MODE_READ;
         // Read partly along the cursor row, where the text is.
         if (pick < 90) begin
            r.pos_x = XW'($urandom_range(0, COLS - 1));
            r.pos_y = (pick < 80) ? YW'(cur_row) : YW'($urandom_range(0, NROWS - 1));
         end
      end else begin
         r.mode = MODE_CLEAR;
      end
      return r;
   endfunction

   // Offer one item, hold it until accepted, then book the result it owes.
   task automatic send_cmd(input req_type cmd, input bit typed = 1'b0,
                           input rsp_type want = '0);
      rsp_type pred;
      @(negedge clock);
      if (!calm_tail && $urandom_range(0, 3) == 0) begin
         // Idle the request side for a burst; scramble the payload meanwhile.
         req_valid <= 1'b0;
         req_data <= req_type'(REQ_W'($urandom));
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (req_ready !== 1'b1);
      pred = apply_command(cmd);
      pending_results.push_back(typed ? want : pred);
      items_sent++;
      if (pred.scrolled) scrolls_seen++;
      if (cmd.mode == MODE_CLEAR) clears_seen++;
      if (cmd.mode == MODE_READ) reads_seen++;
   endtask

   // Write the attribute register once the block has drained.
   task automatic set_color(input logic [CHW-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      attr_now = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random traffic: mostly well-formed editing sequences, some loose commands.
   task automatic run_random(input int goal);
      int stop;
      int kind;
      int n;
      int x;
      stop = items_sent + goal;
      while (items_sent < stop) begin
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            send_cmd(random_cmd());
         end else if (kind < 6) begin
            // Type a run of text, sometimes long enough to wrap, then sometimes end the line.
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 100) : $urandom_range(1, 30);
            repeat (n) begin
               send_cmd(make_cmd(MODE_PUT, $urandom_range(32, 126),
                                 $urandom_range(0, 127), $urandom_range(0, 31)));
            end
            if ($urandom_range(0, 1) == 1) begin
               send_cmd(make_cmd(MODE_PUT, control_char($urandom_range(0, 1)),
                                 $urandom_range(0, 127), $urandom_range(0, 31)));
            end
         end else if (kind < 7) begin
            // Jump to column 0 below the top row and back up into the row above.
            send_cmd(make_cmd(MODE_SET, $urandom_range(0, 255), 0, $urandom_range(1, NROWS - 1)));
            repeat ($urandom_range(1, 3)) begin
               send_cmd(make_cmd(MODE_PUT, CH_BACKSPACE, $urandom_range(0, 127),
                                 $urandom_range(0, 31)));
            end
         end else if (kind < 9) begin
            // Fill a row to its end, last cell sometimes a space, then back up
            // across the wrap: exercises both the clamp and the search.
            x = $urandom_range(COLS - 4, COLS - 1);
            send_cmd(make_cmd(MODE_SET, 0, x, $urandom_range(0, NROWS - 2)));
            for (int c = x; c < COLS; c++) begin
               send_cmd(make_cmd(MODE_PUT, (c == COLS - 1 && $urandom_range(0, 2) == 0) ?
                                 CH_SPACE : $urandom_range(33, 126), 0, 0));
            end
            repeat ($urandom_range(1, 2)) send_cmd(make_cmd(MODE_PUT, CH_BACKSPACE, 0, 0));
         end else begin
            // Park near the bottom right and push past it to force a scroll.
            send_cmd(make_cmd(MODE_SET, 0, $urandom_range(COLS - 9, COLS - 1), NROWS - 1));
            repeat ($urandom_range(1, 2)) begin
               case ($urandom_range(0, 2))
                  0: send_cmd(make_cmd(MODE_PUT, CH_NEWLINE, 0, 0));
                  1: send_cmd(make_cmd(MODE_PUT, CH_TAB, 0, 0));
                  default: send_cmd(make_cmd(MODE_PUT, $urandom_range(33, 255), 0, 0));
               endcase
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random back-pressure bursts, none in the calm tail
   // ---------------------------------------------------------------------
   initial begin : rsp_pacing
      int hold;
      hold = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
            hold = $urandom_range(0, 7);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each delivered result with the oldest one owed.
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing owed: expected none, actual %h", $time, rsp_data);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.cursor_row !== want.cursor_row ||
                rsp_data.cursor_column !== want.cursor_column ||
                rsp_data.cell_value !== want.cell_value ||
                rsp_data.scrolled !== want.scrolled) begin
               errors++;
               $display("%0t: result %0d mismatch: expected row %0d col %0d cell %h scroll %b,",
                        $time, results_seen, want.cursor_row, want.cursor_column,
                        want.cell_value, want.scrolled);
               $display("%0t:   actual row %0d col %0d cell %h scroll %b", $time,
                        rsp_data.cursor_row, rsp_data.cursor_column, rsp_data.cell_value,
                        rsp_data.scrolled);
            end
         end
      end
   end

   // Watchdog: end the run if no channel moves an item for too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready) ||
             (csr_valid && csr_ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no item moved for %0d cycles, %0d results still owed", $time,
               idle_cycles, pending_results.size());
      $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_flow
      logic [CHW-1:0] mid_color;

      // Hold every input at a known value and the block in reset.
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      attr_now = RESET_COLOR;
      cur_row = 0;
      cur_col = 0;
      for (int i = 0; i < CELLS; i++) shadow_screen[i] = RESET_BLANK;

      // Directed rows: reads at the corners and off screen, every control
      // character, wrap at the last column, backspace into a full line and
      // into an empty one, ignored cursor moves, scrolls by tab, by print and
      // by newline, and a clear.
      add_row(MODE_READ, 0, 0, 0, 1, 0, 0, RESET_BLANK);
      add_row(MODE_READ, 255, COLS - 1, NROWS - 1, 1, 0, 0, RESET_BLANK);
      add_row(MODE_READ, 0, COLS, 0, 1, 0, 0, 0);
      add_row(MODE_READ, 0, 127, 31, 1, 0, 0, 0);
      add_row(MODE_PUT, 8'h41, 0, 0, 1, 0, 1);
      add_row(MODE_PUT, 8'hFF, 127, 31, 1, 0, 2);
      add_row(MODE_PUT, 8'h00, 0, 0, 1, 0, 3);
      add_row(MODE_PUT, CH_BACKSPACE, 0, 0, 1, 0, 2);
      add_row(MODE_PUT, CH_TAB, 0, 0, 1, 0, 8);
      add_row(MODE_PUT, CH_RETURN, 0, 0, 1, 0, 0);
      add_row(MODE_PUT, CH_BACKSPACE, 0, 0, 1, 0, 0);
      add_row(MODE_PUT, CH_NEWLINE, 0, 0, 1, 1, 0);
      add_row(MODE_PUT, CH_BACKSPACE, 0, 0);
      add_row(MODE_READ, 0, 1, 0);
      add_row(MODE_SET, 0, COLS - 1, 0, 1, 0, COLS - 1);
      add_row(MODE_PUT, 8'h5A, 0, 0, 1, 1, 0);
      add_row(MODE_PUT, CH_BACKSPACE, 0, 0);
      add_row(MODE_SET, 0, COLS, 3, 1, 0, COLS - 1);
      add_row(MODE_SET, 0, 5, NROWS, 1, 0, COLS - 1);
      add_row(MODE_SET, 0, 72, NROWS - 1, 1, NROWS - 1, 72);
      add_row(MODE_PUT, CH_TAB, 0, 0);
      add_row(MODE_SET, 0, COLS - 1, NROWS - 1, 1, NROWS - 1, COLS - 1);
      add_row(MODE_PUT, 8'h23, 0, 0);
      add_row(MODE_PUT, CH_NEWLINE, 0, 0);
      add_row(MODE_READ, 0, COLS - 1, NROWS - 3);
      add_row(MODE_CLEAR, 8'hFF, 127, 31, 1, 0, 0);
      add_row(MODE_PUT, CH_NEWLINE, 0, 0, 1, 1, 0);
      add_row(MODE_PUT, CH_BACKSPACE, 0, 0);
      add_row(MODE_READ, 0, 0, 0);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Walk the directed table under the reset attribute; the block's own
      // clearing pass after reset simply holds off the first item.
      for (int i = 0; i < dir_count; i++)
         send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

      // Random phases, each under its own attribute: both extremes, a middle
      // value, then a calm tail with no idling on either side.
      set_color(8'h00);
      run_random(150);
      set_color(8'hFF);
      run_random(150);
      mid_color = CHW'($urandom_range(1, 254));
      set_color(mid_color);
      run_random(150);
      calm_tail = 1'b1;
      set_color(RESET_COLOR);
      run_random(150);

      // Drop valid, drain what is owed, then watch a little longer for strays.
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d commands (%0d reads, %0d clears, %0d scrolls)",
               items_sent, reads_seen, clears_seen, scrolls_seen);
      $display("under attributes 07 00 ff %h 07", mid_color);
      $display("Checked %0d results, %0d mismatches", results_seen, errors);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_dpath.sv
rtl/core/text_console_writer.sv
tb/tb_text_console_writer.sv
